@@ rtl/sfpc_pkg.sv @@
// sfpc_pkg: shared types and codes for the size-class free-pointer cache.
// Payload structs, request/result codes and the controller/datapath link.
// No dependencies.
package sfpc_pkg;

  localparam int PTR_W = 48;   // pointer field width on both channels

  typedef enum logic [1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_FREE   = 2'd1,
    REQ_REFILL = 2'd2,
    REQ_NONE   = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    KIND_ALLOC      = 2'd0,
    KIND_OOM        = 2'd1,
    KIND_REFILL_REQ = 2'd2,
    KIND_FLUSH      = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [2:0]       size_class;
    logic [PTR_W-1:0] pointer;
    logic             has_pointer;
    logic             last;
  } req_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [2:0]       out_class;
    logic [PTR_W-1:0] out_pointer;
    logic [5:0]       request_count;
    logic             last_of_run;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic  capture;
    logic  push;
    logic  pop;
    logic  set_pending;
    logic  clr_pending;
    logic  flush_load;
    logic  flush_step;
    logic  emit;
    kind_e kind;
    logic  last;
  } sfpc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    req_type_e req_type;
    logic      cls_ok;
    logic      cnt_zero;
    logic      cnt_lt_cap;
    logic      cnt_lt_hw;
    logic      pending;
    logic      has_ptr;
    logic      last;
    logic      flush_due;
    logic      flush_last;
    logic      slot_free;
  } sfpc_status_t;

endpackage

@@ rtl/sfpc_ctrl.sv @@
// sfpc_ctrl: sequencing state machine of the free-pointer cache.
// Depends on sfpc_pkg; drives sfpc_dp through sfpc_cmd_t.
module sfpc_ctrl import sfpc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         req_valid,
  output logic         req_ready,
  input  sfpc_status_t status,
  output sfpc_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ANSWER,
    S_FLUSH,
    S_OUT
  } state_t;

  state_t state, state_next;
  kind_e  kind_q, kind_next;
  logic   last_q, last_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    kind_next  = kind_q;
    last_next  = last_q;
    unique case (state)
      S_IDLE: begin
        cmd.capture = req_valid;
        if (req_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        unique case (status.req_type)
          REQ_ALLOC: begin
            last_next = 1'b1;
            if (!status.cls_ok) begin
              state_next = S_IDLE;
            end else if (!status.cnt_zero) begin
              cmd.pop    = 1'b1;
              kind_next  = KIND_ALLOC;
              state_next = S_OUT;
            end else if (status.pending) begin
              kind_next  = KIND_OOM;
              state_next = S_OUT;
            end else begin
              cmd.set_pending = 1'b1;
              kind_next       = KIND_REFILL_REQ;
              state_next      = S_OUT;
            end
          end
          REQ_FREE: begin
            if (!status.cls_ok) begin
              state_next = S_IDLE;
            end else begin
              cmd.push = status.cnt_lt_cap;
              if (status.flush_due) begin
                cmd.flush_load = 1'b1;
                state_next     = S_FLUSH;
              end else begin
                state_next = S_IDLE;
              end
            end
          end
          REQ_REFILL: begin
            if (!status.pending) begin
              state_next = S_IDLE;
            end else begin
              cmd.push = status.has_ptr & status.cnt_lt_hw;
              if (status.last) begin
                cmd.clr_pending = 1'b1;
                state_next      = S_ANSWER;
              end else begin
                state_next = S_IDLE;
              end
            end
          end
          REQ_NONE: state_next = S_IDLE;
        endcase
      end
      S_ANSWER: begin
        // count now includes the last refill push
        last_next  = 1'b1;
        state_next = S_OUT;
        if (!status.cnt_zero) begin
          cmd.pop   = 1'b1;
          kind_next = KIND_ALLOC;
        end else begin
          kind_next = KIND_OOM;
        end
      end
      S_FLUSH: begin
        cmd.pop        = 1'b1;
        cmd.flush_step = 1'b1;
        kind_next      = KIND_FLUSH;
        last_next      = status.flush_last;
        state_next     = S_OUT;
      end
      S_OUT: begin
        cmd.kind = kind_q;
        cmd.last = last_q;
        if (status.slot_free) begin
          cmd.emit   = 1'b1;
          state_next = (kind_q == KIND_FLUSH && !last_q) ? S_FLUSH : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      kind_q <= KIND_ALLOC;
      last_q <= 1'b0;
    end else begin
      state  <= state_next;
      kind_q <= kind_next;
      last_q <= last_next;
    end
  end

endmodule

@@ rtl/sfpc_dp.sv @@
// sfpc_dp: datapath of the free-pointer cache: item register, per-class
// counts, pointer memory, flush counter, result register. Uses sfpc_pkg.
module sfpc_dp import sfpc_pkg::*; #(
  parameter int NUM_CLASSES = 8,
  parameter int BATCH       = 32,
  parameter int HIGH_WATER  = 64,
  parameter int PTR_WIDTH   = 48
) (
  input  logic         clk,
  input  logic         rst,
  input  req_t         req_data,
  input  logic         rsp_ready,
  output logic         rsp_valid,
  output rsp_t         rsp_data,
  input  sfpc_cmd_t    cmd,
  output sfpc_status_t status
);

  localparam int NCLS_EFF  = (NUM_CLASSES < 8) ? NUM_CLASSES : 8;
  localparam int CIDX_W    = (NCLS_EFF > 1) ? $clog2(NCLS_EFF) : 1;
  localparam int CNT_DEPTH = 1 << CIDX_W;
  localparam int IDX_W     = (HIGH_WATER > 0) ? $clog2(HIGH_WATER + 1) : 1;
  localparam int CNT_W     = $clog2(HIGH_WATER + 2);
  localparam int ADDR_W    = CIDX_W + IDX_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam int SW        = (PTR_WIDTH < PTR_W) ? PTR_WIDTH : PTR_W;
  localparam int FL_W      = $clog2(BATCH + 1);

  req_t              item;
  logic              pending;
  logic [2:0]        pending_class;
  logic [CNT_W-1:0]  class_count [CNT_DEPTH];
  logic [SW-1:0]     ptr_mem [MEM_DEPTH];
  logic [SW-1:0]     rdata;
  logic [FL_W-1:0]   flush_rem;

  logic [2:0]        cur_cls;
  logic [CIDX_W-1:0] cidx;
  logic [CNT_W-1:0]  cnt, cnt_dec, newcnt_free;
  logic              cnt_lt_cap;
  logic [ADDR_W-1:0] wr_addr, rd_addr;

  // refill items address the class that is waiting, all else their own
  assign cur_cls     = (item.req_type == REQ_REFILL) ? pending_class : item.size_class;
  assign cidx        = cur_cls[CIDX_W-1:0];
  assign cnt         = class_count[cidx];
  assign cnt_dec     = cnt - CNT_W'(1);
  assign cnt_lt_cap  = cnt < CNT_W'(HIGH_WATER + 1);
  assign newcnt_free = cnt + CNT_W'(cnt_lt_cap);
  assign wr_addr     = {cidx, cnt[IDX_W-1:0]};
  assign rd_addr     = {cidx, cnt_dec[IDX_W-1:0]};

  always_comb begin
    status            = '0;
    status.req_type   = req_type_e'(item.req_type);
    status.cls_ok     = int'(item.size_class) < NUM_CLASSES;
    status.cnt_zero   = (cnt == '0);
    status.cnt_lt_cap = cnt_lt_cap;
    status.cnt_lt_hw  = cnt < CNT_W'(HIGH_WATER);
    status.pending    = pending;
    status.has_ptr    = item.has_pointer;
    status.last       = item.last;
    status.flush_due  = newcnt_free > CNT_W'(HIGH_WATER);
    status.flush_last = (flush_rem == FL_W'(1));
    status.slot_free  = !rsp_valid || rsp_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) item <= req_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending       <= 1'b0;
      pending_class <= '0;
    end else if (cmd.set_pending) begin
      pending       <= 1'b1;
      pending_class <= item.size_class;
    end else if (cmd.clr_pending) begin
      pending <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CNT_DEPTH; i++) class_count[i] <= '0;
    end else if (cmd.push) begin
      class_count[cidx] <= cnt + CNT_W'(1);
    end else if (cmd.pop) begin
      class_count[cidx] <= cnt_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) ptr_mem[wr_addr] <= item.pointer[SW-1:0];
    if (cmd.pop)  rdata <= ptr_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flush_rem <= '0;
    end else if (cmd.flush_load) begin
      flush_rem <= (int'(newcnt_free) < BATCH) ? FL_W'(newcnt_free) : FL_W'(BATCH);
    end else if (cmd.flush_step) begin
      flush_rem <= flush_rem - FL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp_data.kind          <= cmd.kind;
      rsp_data.out_class     <= cur_cls;
      rsp_data.out_pointer   <= (cmd.kind == KIND_ALLOC || cmd.kind == KIND_FLUSH)
                                ? PTR_W'(rdata) : '0;
      rsp_data.request_count <= (cmd.kind == KIND_REFILL_REQ) ? 6'(BATCH) : 6'd0;
      rsp_data.last_of_run   <= cmd.last;
    end
  end

`ifndef SYNTH
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> cnt != '0)
    else $error("pop from an empty class");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> cnt_lt_cap)
    else $error("push into a full class");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    cmd.push |=> cnt == CNT_W'($past(cnt) + CNT_W'(1)))
    else $error("class count did not follow push");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |=> cnt == CNT_W'($past(cnt) - CNT_W'(1)))
    else $error("class count did not follow pop");

  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!rsp_valid || rsp_ready))
    else $error("result overwritten before taken");
`endif

endmodule

@@ rtl/size_class_free_pointer_cache_unit.sv @@
// size_class_free_pointer_cache_unit: top level of the free-pointer cache.
// Instantiates sfpc_ctrl and sfpc_dp; types from sfpc_pkg.
//
//  channel | signals                       | word type | direction
//  --------+-------------------------------+-----------+----------
//  req     | req_valid, req_ready, req_data | req_t     | in
//  rsp     | rsp_valid, rsp_ready, rsp_data | rsp_t     | out
//
// One word at a time: req_ready is high only while the controller is idle.
// Per word, no output stall: a free or refill item executes, then idles;
// an allocate executes, then emits; the last refill item executes, answers
// from the new count, then emits; a free crossing HIGH_WATER then flushes
// pointers one by one (pop from the pointer memory, then emit). The memory
// has one registered-read port. A stalled rsp holds the controller in place.
// Reset clears counts, pending refill and the result valid; the pointer
// memory is not cleared (only entries below a class count are read).
module size_class_free_pointer_cache_unit import sfpc_pkg::*; #(
  parameter int NUM_CLASSES = 8,
  parameter int BATCH       = 32,
  parameter int HIGH_WATER  = 64,
  parameter int PTR_WIDTH   = 48
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req_data,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp_data
);

  sfpc_cmd_t    cmd;
  sfpc_status_t status;

  sfpc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .status    (status),
    .cmd       (cmd)
  );

  sfpc_dp #(
    .NUM_CLASSES (NUM_CLASSES),
    .BATCH       (BATCH),
    .HIGH_WATER  (HIGH_WATER),
    .PTR_WIDTH   (PTR_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req_data),
    .rsp_ready (rsp_ready),
    .rsp_valid (rsp_valid),
    .rsp_data  (rsp_data),
    .cmd       (cmd),
    .status    (status)
  );

`ifndef SYNTH
  // word is captured exactly when the controller leaves idle
  a_capture: assert property (@(posedge clk) disable iff (rst)
    cmd.capture == (req_valid && req_ready))
    else $error("capture does not match request handshake");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("result word changed while stalled");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !req_ready)
    else $error("result emitted while idle");
`endif

endmodule
